// ===== design/drs_pkg.sv =====
// ============================================================================
// drs_pkg: shared types and constants of the DRAM request scheduler
// Operation codes, ordering modes, register indexes and the small structs
// that pass between the scheduler's sub-blocks.
// ============================================================================
`timescale 1ns / 1ps

package drs_pkg;

    // Stream payload layout, input side (tdata, lowest bit first)
    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 2;
    localparam int OFS_SLOT    = 0;
    localparam int OFS_PRESENT = 6;
    localparam int OFS_ISSUED  = 7;
    localparam int OFS_BANK    = 8;
    localparam int OFS_ROW     = 12;
    localparam int OFS_ARRIVAL = 28;
    localparam int OFS_PART    = 76;
    localparam int OFS_BUSY    = 79;
    localparam int OFS_OPEN    = 80;

    // Field widths fixed by the interface
    localparam int SLOT_W    = 6;
    localparam int BANK_W    = 4;
    localparam int ROW_W     = 16;
    localparam int ARRIVAL_W = 48;
    localparam int PART_W    = 3;

    // Stream payload layout, output side
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONTAL = 2'd1;

    // Ordering modes
    localparam int POLICY_W = 3;
    localparam logic [POLICY_W-1:0] POL_FR_FCFS    = 3'd0;
    localparam logic [POLICY_W-1:0] POL_CR_FCFS    = 3'd1;
    localparam logic [POLICY_W-1:0] POL_FRONTAL_FR = 3'd2;
    localparam logic [POLICY_W-1:0] POL_FR_FRONTAL = 3'd3;
    localparam logic [POLICY_W-1:0] POL_PART_FR    = 3'd4;
    localparam logic [POLICY_W-1:0] POL_FR_PART    = 3'd5;

    localparam logic [POLICY_W-1:0]   POLICY_RESET  = POL_FR_FCFS;
    localparam logic [CFG_DATA_W-1:0] FRONTAL_RESET = 3'd1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_BANK   = 2'd1,
        OP_SELECT = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // Scan control toward the ranking unit
    typedef struct packed {
        logic clear;   // start of a new select
        logic vld;     // a read entry sits in the compare stage
    } t_scan_ctl;

    // Bank status of the entry under compare
    typedef struct packed {
        logic avail;   // bank exists and is idle
        logic hit;     // bank's open row matches the entry's row
    } t_bank_stat;

endpackage

// ===== design/dram_request_scheduler.sv =====
// ============================================================================
// dram_request_scheduler: FR-FCFS style DRAM request picker
// Write-entry and set-bank transactions answer one cycle after acceptance.
// A select scans the queue memory one slot per cycle through its single read
// port, then passes the flush and done states before the result is registered;
// no new transaction is taken until the sequencer is idle and the output is free.
// Reset (synchronous, active low) clears entry marks, bank state and config;
// entry payload is not cleared and no clearing pass runs.
// ============================================================================
`timescale 1ns / 1ps

module dram_request_scheduler #(
    parameter int QUEUE_DEPTH = 64,
    parameter int NUM_BANKS   = 16,
    parameter int ROW_BITS    = 16,
    parameter int CYCLE_BITS  = 48,
    parameter int PART_LEVELS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slot[5:0], entry_present[6], already_issued[7], bank_id[11:8],
    // row[27:12], arrival_cycle[75:28], criticality_part[78:76],
    // bank_is_busy[79], row_is_open[80], zero fill[87:81]
    input  logic [drs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // operation[1:0]
    input  logic [drs_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // picked_slot[5:0], row_hit[6], zero fill[7]
    output logic [drs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // found[0]
    output logic [drs_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [drs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [drs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SIW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SEW   = ($clog2(QUEUE_DEPTH + 1) > drs_pkg::SLOT_W) ?
                           $clog2(QUEUE_DEPTH + 1) : drs_pkg::SLOT_W;
    localparam int PW    = $clog2(PART_LEVELS);
    localparam int OFS_R = drs_pkg::BANK_W;
    localparam int OFS_A = OFS_R + ROW_BITS;
    localparam int OFS_P = OFS_A + CYCLE_BITS;
    localparam int WW    = OFS_P + PW;

    // Unpack the input transaction
    drs_pkg::t_op                  in_op;
    logic [drs_pkg::SLOT_W-1:0]    in_slot;
    logic                          in_present;
    logic                          in_issued;
    logic [drs_pkg::BANK_W-1:0]    in_bank;
    logic [drs_pkg::ROW_W-1:0]     in_row;
    logic [drs_pkg::ARRIVAL_W-1:0] in_arrival;
    logic [drs_pkg::PART_W-1:0]    in_part;
    logic                          in_busy;
    logic                          in_open;

    assign in_op      = drs_pkg::t_op'(s_axis_tuser);
    assign in_slot    = s_axis_tdata[drs_pkg::OFS_SLOT +: drs_pkg::SLOT_W];
    assign in_present = s_axis_tdata[drs_pkg::OFS_PRESENT];
    assign in_issued  = s_axis_tdata[drs_pkg::OFS_ISSUED];
    assign in_bank    = s_axis_tdata[drs_pkg::OFS_BANK +: drs_pkg::BANK_W];
    assign in_row     = s_axis_tdata[drs_pkg::OFS_ROW +: drs_pkg::ROW_W];
    assign in_arrival = s_axis_tdata[drs_pkg::OFS_ARRIVAL +: drs_pkg::ARRIVAL_W];
    assign in_part    = s_axis_tdata[drs_pkg::OFS_PART +: drs_pkg::PART_W];
    assign in_busy    = s_axis_tdata[drs_pkg::OFS_BUSY];
    assign in_open    = s_axis_tdata[drs_pkg::OFS_OPEN];

    drs_pkg::t_state                r_state;
    drs_pkg::t_state                n_state;
    logic [SIW-1:0]                 r_cnt;
    logic [SIW-1:0]                 n_cnt;
    logic                           r_p_vld;
    logic [SIW-1:0]                 r_p_idx;
    logic                           r_p_last;
    logic [drs_pkg::POLICY_W-1:0]   r_policy;
    logic [drs_pkg::CFG_DATA_W-1:0] r_limit;
    logic                           r_out_vld;
    logic                           r_out_found;
    logic [drs_pkg::SLOT_W-1:0]     r_out_slot;
    logic                           r_out_hit;

    logic               accept;
    logic               slot_in_range;
    logic [PW-1:0]      part_clamped;
    logic [WW-1:0]      wr_word;
    logic [WW-1:0]      rd_word;
    logic               rd_live;
    logic               scan_issue;
    drs_pkg::t_scan_ctl scan_ctl;
    drs_pkg::t_bank_stat bank_stat;
    logic               best_found;
    logic [SIW-1:0]     best_slot;
    logic               best_hit;

    assign s_axis_tready = (r_state == drs_pkg::ST_IDLE) && (!r_out_vld || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Clamp the part class and pack the entry word
    always_comb begin
        slot_in_range = SEW'(in_slot) < SEW'(QUEUE_DEPTH);
        if (int'(in_part) >= PART_LEVELS) begin
            part_clamped = PW'(PART_LEVELS - 1);
        end else begin
            part_clamped = PW'(in_part);
        end
        wr_word = {part_clamped, CYCLE_BITS'(in_arrival), ROW_BITS'(in_row), in_bank};
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= drs_pkg::POLICY_RESET;
            r_limit  <= drs_pkg::FRONTAL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                drs_pkg::CFG_POLICY:  r_policy <= i_cfg_data;
                drs_pkg::CFG_FRONTAL: r_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequence: next state and scan address
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        scan_issue = 1'b0;
        case (r_state)
            drs_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (accept && (in_op == drs_pkg::OP_SELECT)) begin
                    n_state = drs_pkg::ST_SCAN;
                end
            end
            drs_pkg::ST_SCAN: begin
                scan_issue = 1'b1;
                n_cnt      = r_cnt + SIW'(1);
                if (r_cnt == SIW'(QUEUE_DEPTH - 1)) begin
                    n_state = drs_pkg::ST_FLUSH;
                end
            end
            drs_pkg::ST_FLUSH: begin
                n_state = drs_pkg::ST_DONE;
            end
            drs_pkg::ST_DONE: begin
                n_state = drs_pkg::ST_IDLE;
            end
            default: begin
                n_state = drs_pkg::ST_IDLE;
            end
        endcase
        scan_ctl.clear = accept && (in_op == drs_pkg::OP_SELECT);
        scan_ctl.vld   = r_p_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drs_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_p_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_p_vld <= scan_issue;
        end
    end

    // Tag the entry that arrives from memory next cycle
    always_ff @(posedge i_clk) begin
        r_p_idx  <= r_cnt;
        r_p_last <= (r_cnt == SIW'(QUEUE_DEPTH - 1));
    end

    drs_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WW),
        .AW    (SIW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (accept && (in_op == drs_pkg::OP_WRITE) && slot_in_range),
        .i_wr_addr   (SIW'(in_slot)),
        .i_wr_valid  (in_present),
        .i_wr_issued (in_issued),
        .i_wr_word   (wr_word),
        .i_rd_addr   (r_cnt),
        .o_rd_word   (rd_word),
        .o_rd_live   (rd_live)
    );

    drs_bank_table #(
        .NUM_BANKS (NUM_BANKS),
        .ROW_BITS  (ROW_BITS)
    ) u_banks (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept && (in_op == drs_pkg::OP_BANK)),
        .i_wr_bank (in_bank),
        .i_wr_busy (in_busy),
        .i_wr_open (in_open),
        .i_wr_row  (ROW_BITS'(in_row)),
        .i_q_bank  (rd_word[0 +: drs_pkg::BANK_W]),
        .i_q_row   (rd_word[OFS_R +: ROW_BITS]),
        .o_stat    (bank_stat)
    );

    drs_rank #(
        .CYCLE_BITS (CYCLE_BITS),
        .PW         (PW),
        .SIW        (SIW)
    ) u_rank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_slot    (r_p_idx),
        .i_live    (rd_live),
        .i_stat    (bank_stat),
        .i_arrival (rd_word[OFS_A +: CYCLE_BITS]),
        .i_part    (rd_word[OFS_P +: PW]),
        .i_policy  (r_policy),
        .i_limit   (r_limit),
        .o_found   (best_found),
        .o_slot    (best_slot),
        .o_hit     (best_hit)
    );

    // Output register: zero result for non-select transactions, pick at scan end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (accept && (in_op != drs_pkg::OP_SELECT)) begin
            r_out_vld <= 1'b1;
        end else if (r_state == drs_pkg::ST_DONE) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (in_op != drs_pkg::OP_SELECT)) begin
            r_out_found <= 1'b0;
            r_out_slot  <= '0;
            r_out_hit   <= 1'b0;
        end else if (r_state == drs_pkg::ST_DONE) begin
            r_out_found <= best_found;
            r_out_slot  <= drs_pkg::SLOT_W'(best_slot);
            r_out_hit   <= best_hit;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {1'b0, r_out_hit, r_out_slot};

    // The output register is free for the whole scan
    a_scan_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drs_pkg::ST_SCAN) |-> !r_out_vld)
        else $error("result pending during a queue scan");

    // The flush cycle compares the last slot of the queue
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drs_pkg::ST_FLUSH) |-> (r_p_vld && r_p_last))
        else $error("scan pipeline out of step with the sequencer");

    // Non-select transactions answer on the next cycle
    a_quick_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_op != drs_pkg::OP_SELECT)) |=> (r_out_vld && !r_out_found))
        else $error("missing zero result for a non-select transaction");

    // A result without a pick carries no slot and no hit
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_found) |-> (r_out_slot == '0 && !r_out_hit))
        else $error("empty result carries slot or hit");

endmodule

// ===== design/drs_queue_mem.sv =====
// ============================================================================
// drs_queue_mem: request queue storage
// Entry payload in a single-port-write, registered-read memory; valid and
// issued marks in flops cleared by reset.
// ============================================================================
`timescale 1ns / 1ps

module drs_queue_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 71,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic             i_wr_valid,
    input  logic             i_wr_issued,
    input  logic [WIDTH-1:0] i_wr_word,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_word,
    output logic             o_rd_live
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DEPTH-1:0] r_issued;
    logic [WIDTH-1:0] r_rd_word;
    logic             r_rd_live;

    // Write and read the payload memory
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_word;
        end
        r_rd_word <= r_mem[i_rd_addr];
    end

    // Hold the entry marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_issued  <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr]  <= i_wr_valid;
                r_issued[i_wr_addr] <= i_wr_issued;
            end
            r_rd_live <= r_valid[i_rd_addr] & ~r_issued[i_rd_addr];
        end
    end

    assign o_rd_word = r_rd_word;
    assign o_rd_live = r_rd_live;

endmodule

// ===== design/drs_bank_table.sv =====
// ============================================================================
// drs_bank_table: per-bank busy and open-row state
// Updated by set-bank transactions; looked up with the bank and row of the
// entry under compare.
// ============================================================================
`timescale 1ns / 1ps

module drs_bank_table #(
    parameter int NUM_BANKS = 16,
    parameter int ROW_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [drs_pkg::BANK_W-1:0] i_wr_bank,
    input  logic                      i_wr_busy,
    input  logic                      i_wr_open,
    input  logic [ROW_BITS-1:0]       i_wr_row,
    input  logic [drs_pkg::BANK_W-1:0] i_q_bank,
    input  logic [ROW_BITS-1:0]       i_q_row,
    output drs_pkg::t_bank_stat       o_stat
);

    localparam int BIW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int BEW = ($clog2(NUM_BANKS + 1) > drs_pkg::BANK_W) ?
                         $clog2(NUM_BANKS + 1) : drs_pkg::BANK_W;

    logic [NUM_BANKS-1:0] r_busy;
    logic [NUM_BANKS-1:0] r_open;
    logic [ROW_BITS-1:0]  r_row [NUM_BANKS];

    logic [BEW-1:0] wr_ext;
    logic [BEW-1:0] q_ext;
    logic [BIW-1:0] wr_idx;
    logic [BIW-1:0] q_idx;
    logic           wr_in_range;
    logic           q_in_range;

    assign wr_ext      = BEW'(i_wr_bank);
    assign q_ext       = BEW'(i_q_bank);
    assign wr_in_range = wr_ext < BEW'(NUM_BANKS);
    assign q_in_range  = q_ext < BEW'(NUM_BANKS);
    assign wr_idx      = wr_ext[BIW-1:0];
    assign q_idx       = q_ext[BIW-1:0];

    // Update bank state; drop sets of banks that do not exist
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            r_open <= '0;
        end else if (i_wr_en && wr_in_range) begin
            r_busy[wr_idx] <= i_wr_busy;
            r_open[wr_idx] <= i_wr_open;
        end
    end

    // Open row needs no reset: it only counts while the open mark is set
    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in_range) begin
            r_row[wr_idx] <= i_wr_row;
        end
    end

    // Look up the entry's bank
    always_comb begin
        o_stat.avail = 1'b0;
        o_stat.hit   = 1'b0;
        if (q_in_range) begin
            o_stat.avail = ~r_busy[q_idx];
            o_stat.hit   = r_open[q_idx] && (r_row[q_idx] == i_q_row);
        end
    end

endmodule

// ===== design/drs_rank.sv =====
// ============================================================================
// drs_rank: ranking and best-candidate tracking
// Builds the ordering key of each scanned entry under the current mode and
// keeps the best eligible entry seen so far in this select.
// ============================================================================
`timescale 1ns / 1ps

module drs_rank #(
    parameter int CYCLE_BITS = 48,
    parameter int PW         = 3,
    parameter int SIW        = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  drs_pkg::t_scan_ctl            i_ctl,
    input  logic [SIW-1:0]                i_slot,
    input  logic                          i_live,
    input  drs_pkg::t_bank_stat           i_stat,
    input  logic [CYCLE_BITS-1:0]         i_arrival,
    input  logic [PW-1:0]                 i_part,
    input  logic [drs_pkg::POLICY_W-1:0]  i_policy,
    input  logic [drs_pkg::CFG_DATA_W-1:0] i_limit,
    output logic                          o_found,
    output logic [SIW-1:0]                o_slot,
    output logic                          o_hit
);

    localparam int KW   = (PW > drs_pkg::CFG_DATA_W) ? PW : drs_pkg::CFG_DATA_W;
    localparam int KEYW = 2 * KW + CYCLE_BITS;

    logic            r_have;
    logic [KEYW-1:0] r_best_key;
    logic [SIW-1:0]  r_best_slot;
    logic            r_best_hit;

    logic [KW-1:0]   k1;
    logic [KW-1:0]   k2;
    logic [KW-1:0]   part_k;
    logic            miss;
    logic            back;
    logic [KEYW-1:0] key;
    logic            take;

    // Form the ordering keys; lower is better
    always_comb begin
        part_k = KW'(i_part);
        miss   = ~i_stat.hit;
        back   = part_k > KW'(i_limit);
        case (i_policy)
            drs_pkg::POL_CR_FCFS: begin
                k1 = KW'(i_stat.hit);
                k2 = '0;
            end
            drs_pkg::POL_FRONTAL_FR: begin
                k1 = KW'(back);
                k2 = KW'(miss);
            end
            drs_pkg::POL_FR_FRONTAL: begin
                k1 = KW'(miss);
                k2 = KW'(back);
            end
            drs_pkg::POL_PART_FR: begin
                k1 = part_k;
                k2 = KW'(miss);
            end
            drs_pkg::POL_FR_PART: begin
                k1 = KW'(miss);
                k2 = part_k;
            end
            default: begin
                k1 = KW'(miss);
                k2 = '0;
            end
        endcase
        key  = {k1, k2, i_arrival};
        // Strictly better only, so ties stay with the lower slot
        take = i_ctl.vld && i_live && i_stat.avail && (!r_have || (key < r_best_key));
    end

    // Track whether any candidate was taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have <= 1'b0;
        end else if (take) begin
            r_have <= 1'b1;
        end
    end

    // Hold the best candidate
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_key  <= key;
            r_best_slot <= i_slot;
            r_best_hit  <= i_stat.hit;
        end
    end

    assign o_found = r_have;
    assign o_slot  = r_have ? r_best_slot : '0;
    assign o_hit   = r_have & r_best_hit;

endmodule
